[design/bgi_pkg.sv]
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared types, codes and widths for the battery gauge LED indicator.
// ----------------------------------------------------------------------------
package bgi_pkg;

  // Default ADC sample width
  localparam int ADC_BITS_DEF = 12;

  // Field widths fixed by the event format
  localparam int KIND_W   = 3;
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 8;
  localparam int PHASE_W  = 2;
  localparam int LED_W    = 5;
  localparam int GEAR_W   = 3;
  localparam int CFG_IDX_W = 2;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_EVALUATE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MODE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SET_WRITE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REFRESH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ENTER_SET = 3'd4;

  // Modes
  localparam logic [MODE_W-1:0] MODE_OFF       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BATTERY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GEAR_SET  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RATE_SET  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RATE_SHOW = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CHARGING  = 3'd5;

  // Charge phases
  localparam logic [PHASE_W-1:0] PHASE_TRICKLE = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_FULL    = 2'd2;

  // Gears
  localparam logic [GEAR_W-1:0] GEAR_NONE = 3'd0;
  localparam logic [GEAR_W-1:0] GEAR_TOP  = 3'd5;
  localparam logic [GEAR_W-1:0] GEAR_FULL = 3'd6;

  // Discharge rate codes that light an LED
  localparam logic [VALUE_W-1:0] RATE_ONE   = 8'd1;
  localparam logic [VALUE_W-1:0] RATE_TWO   = 8'd2;
  localparam logic [VALUE_W-1:0] RATE_THREE = 8'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_3 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_4 = 2'd3;

  // One event, less the ADC sample
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [MODE_W-1:0]  mode_value;
    logic               set_target;
    logic [VALUE_W-1:0] set_value;
    logic [PHASE_W-1:0] charge_phase;
    logic               setting_exit_event;
    logic               indicator_exit_event;
    logic               lamp_on;
    logic               lamp_allowed_in_setting;
  } bgi_item_t;

  // Architectural state of the gauge
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [LED_W-1:0]   leds;
    logic [GEAR_W-1:0]  last_gear;
    logic [GEAR_W-1:0]  charge_gear;
    logic [VALUE_W-1:0] rate_setting;
    logic [VALUE_W-1:0] initial_gear;
    logic               in_setting;
  } bgi_state_t;

  // Blink flag that goes with a setting write
  typedef struct packed {
    logic               request;
    logic [VALUE_W-1:0] value;
  } bgi_blink_t;

endpackage

[design/bgi_if.sv]
// ----------------------------------------------------------------------------
// bgi_if
// Channel interfaces of the gauge: event input, result output, register write.
// ----------------------------------------------------------------------------
interface bgi_in_if #(
  parameter int ADC_BITS = bgi_pkg::ADC_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [bgi_pkg::KIND_W-1:0]   kind;
  logic [bgi_pkg::MODE_W-1:0]   mode_value;
  logic                         set_target;
  logic [bgi_pkg::VALUE_W-1:0]  set_value;
  logic [ADC_BITS-1:0]          battery_level;
  logic [bgi_pkg::PHASE_W-1:0]  charge_phase;
  logic                         setting_exit_event;
  logic                         indicator_exit_event;
  logic                         lamp_on;
  logic                         lamp_allowed_in_setting;

  modport source (
    output valid, kind, mode_value, set_target, set_value, battery_level,
           charge_phase, setting_exit_event, indicator_exit_event, lamp_on,
           lamp_allowed_in_setting,
    input  ready
  );
  modport sink (
    input  valid, kind, mode_value, set_target, set_value, battery_level,
           charge_phase, setting_exit_event, indicator_exit_event, lamp_on,
           lamp_allowed_in_setting,
    output ready
  );
endinterface

interface bgi_out_if;
  logic                         valid;
  logic                         ready;
  logic [bgi_pkg::LED_W-1:0]    led_pattern;
  logic [bgi_pkg::MODE_W-1:0]   current_mode;
  logic [bgi_pkg::GEAR_W-1:0]   charging_gear;
  logic [bgi_pkg::VALUE_W-1:0]  discharge_rate;
  logic [bgi_pkg::VALUE_W-1:0]  initial_gear;
  logic                         blink_request;
  logic [bgi_pkg::VALUE_W-1:0]  blink_value;

  modport source (
    output valid, led_pattern, current_mode, charging_gear, discharge_rate,
           initial_gear, blink_request, blink_value,
    input  ready
  );
  modport sink (
    input  valid, led_pattern, current_mode, charging_gear, discharge_rate,
           initial_gear, blink_request, blink_value,
    output ready
  );
endinterface

interface bgi_cfg_if #(
  parameter int ADC_BITS = bgi_pkg::ADC_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [bgi_pkg::CFG_IDX_W-1:0] index;
  logic [ADC_BITS-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/bgi_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bgi_cfg_regs
// Level threshold registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module bgi_cfg_regs #(
  parameter int ADC_BITS = bgi_pkg::ADC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [bgi_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ADC_BITS-1:0]      wr_data,
  output logic [3:0][ADC_BITS-1:0] thr
);
  import bgi_pkg::*;

  // Reset levels at one quarter, half, three quarters and seven eighths of scale
  localparam logic [ADC_BITS-1:0] THR1_RST = ADC_BITS'(1) << (ADC_BITS - 2);
  localparam logic [ADC_BITS-1:0] THR2_RST = ADC_BITS'(1) << (ADC_BITS - 1);
  localparam logic [ADC_BITS-1:0] THR3_RST = ADC_BITS'(3) << (ADC_BITS - 2);
  localparam logic [ADC_BITS-1:0] THR4_RST = ADC_BITS'(7) << (ADC_BITS - 3);

  logic [3:0][ADC_BITS-1:0] thr_r;
  logic [3:0][ADC_BITS-1:0] thr_nxt;

  // Decode the write
  always_comb begin
    thr_nxt = thr_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_LEVEL_1: thr_nxt[0] = wr_data;
        REG_LEVEL_2: thr_nxt[1] = wr_data;
        REG_LEVEL_3: thr_nxt[2] = wr_data;
        REG_LEVEL_4: thr_nxt[3] = wr_data;
        default:     thr_nxt = thr_r;
      endcase
    end
  end

  // Hold the thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0] <= THR1_RST;
      thr_r[1] <= THR2_RST;
      thr_r[2] <= THR3_RST;
      thr_r[3] <= THR4_RST;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign thr = thr_r;

endmodule

[design/bgi_event_logic.sv]
// ----------------------------------------------------------------------------
// bgi_event_logic
// Next-state logic: applies one event to the gauge state.
// ----------------------------------------------------------------------------
module bgi_event_logic #(
  parameter int ADC_BITS = bgi_pkg::ADC_BITS_DEF
) (
  input  bgi_pkg::bgi_item_t       item,
  input  logic [ADC_BITS-1:0]      level,
  input  logic [3:0][ADC_BITS-1:0] thr,
  input  bgi_pkg::bgi_state_t      st,
  output bgi_pkg::bgi_state_t      st_nxt,
  output bgi_pkg::bgi_blink_t      blink
);
  import bgi_pkg::*;

  logic [GEAR_W-1:0] lvl_gear;
  logic [GEAR_W-1:0] bat_gear;
  logic [GEAR_W-1:0] chg_raw;
  logic [GEAR_W-1:0] chg_gear;
  logic [LED_W-1:0]  bat_leds;
  logic [LED_W-1:0]  chg_leds;
  logic [LED_W-1:0]  rate_leds;

  // Map the ADC level to a gear of one to five
  always_comb begin
    if (level > thr[3])      lvl_gear = GEAR_TOP;
    else if (level > thr[2]) lvl_gear = 3'd4;
    else if (level > thr[1]) lvl_gear = 3'd3;
    else if (level > thr[0]) lvl_gear = 3'd2;
    else                     lvl_gear = 3'd1;
  end

  // Battery gear never rises, charging gear never falls
  always_comb begin
    bat_gear = lvl_gear;
    if (st.last_gear != GEAR_NONE && lvl_gear > st.last_gear) begin
      bat_gear = st.last_gear;
    end
    chg_raw = lvl_gear;
    if (item.charge_phase == PHASE_TRICKLE || item.charge_phase == PHASE_FULL) begin
      chg_raw = GEAR_FULL;
    end
    chg_gear = chg_raw;
    if (st.last_gear != GEAR_NONE && chg_raw < st.last_gear) begin
      chg_gear = st.last_gear;
    end
  end

  // Segment patterns for each indicating mode
  always_comb begin
    bat_leds = {bat_gear >= GEAR_TOP, bat_gear >= 3'd4, bat_gear >= 3'd3,
                bat_gear >= 3'd2, 1'b1};
    chg_leds = st.leds | {chg_gear >= GEAR_FULL, chg_gear >= GEAR_TOP,
                          chg_gear >= 3'd4, chg_gear >= 3'd3, 1'b1};
    rate_leds = st.leds;
    case (st.rate_setting)
      RATE_ONE:   rate_leds = st.leds | LED_W'(1);
      RATE_TWO:   rate_leds = st.leds | LED_W'(2);
      RATE_THREE: rate_leds = st.leds | LED_W'(4);
      default:    rate_leds = st.leds;
    endcase
  end

  // Apply the event
  always_comb begin
    st_nxt        = st;
    blink.request = 1'b0;
    blink.value   = '0;
    unique case (item.kind)
      KIND_EVALUATE: begin
        if (st.mode == MODE_OFF) begin
          st_nxt.leds = '0;
        end else begin
          case (st.mode) inside
            MODE_BATTERY: begin
              st_nxt.last_gear = bat_gear;
              st_nxt.leds      = bat_leds;
            end
            MODE_RATE_SET, MODE_RATE_SHOW: begin
              st_nxt.leds = rate_leds;
            end
            MODE_CHARGING: begin
              st_nxt.last_gear   = chg_gear;
              st_nxt.charge_gear = chg_gear;
              st_nxt.leds        = chg_leds;
            end
            default: begin
              st_nxt.leds = st.leds;
            end
          endcase
          // Setting exit first, then indicator exit
          if (item.setting_exit_event) begin
            st_nxt.mode = (item.lamp_on && !item.lamp_allowed_in_setting) ?
                          MODE_BATTERY : MODE_OFF;
            st_nxt.in_setting = 1'b0;
          end
          if (item.indicator_exit_event) begin
            st_nxt.mode = MODE_OFF;
          end
          if (st_nxt.mode == MODE_OFF) begin
            st_nxt.leds = '0;
          end
        end
      end
      KIND_MODE: begin
        if (item.mode_value <= MODE_CHARGING) begin
          st_nxt.leds = '0;
          st_nxt.mode = item.mode_value;
        end
      end
      KIND_SET_WRITE: begin
        if (st.in_setting) begin
          if (item.set_target) begin
            st_nxt.rate_setting = item.set_value;
            st_nxt.mode         = MODE_RATE_SET;
          end else begin
            st_nxt.initial_gear = item.set_value;
            st_nxt.mode         = MODE_GEAR_SET;
          end
          st_nxt.leds   = '0;
          blink.request = 1'b1;
          blink.value   = item.set_value;
        end
      end
      KIND_REFRESH: begin
        st_nxt.leds        = '0;
        st_nxt.last_gear   = GEAR_NONE;
        st_nxt.charge_gear = GEAR_NONE;
      end
      KIND_ENTER_SET: begin
        st_nxt.in_setting = 1'b1;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

[design/battery_gauge_led_indicator_unit.sv]
// Each accepted event is held in the input register and its result then moves
// to the result register; a stall on the result side holds both back.
// Throughput: one event per cycle while the result side does not stall; the next
// event is taken as the result of the previous one leaves the result register.
// Reset: synchronous active-low rst_n clears mode, LEDs, gears, settings and
// valids, and loads the default thresholds; no clearing pass is needed.
// ----------------------------------------------------------------------------
// battery_gauge_led_indicator_unit
// Five-LED battery gauge: registers each event, applies it to the mode and
// gauge state and registers the result for the output channel.
// ----------------------------------------------------------------------------
module battery_gauge_led_indicator_unit #(
  parameter int ADC_BITS = bgi_pkg::ADC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bgi_in_if.sink    in_ch,
  bgi_out_if.source out_ch,
  bgi_cfg_if.sink   cfg_ch
);
  import bgi_pkg::*;

  logic [3:0][ADC_BITS-1:0] thr;

  logic                s1_valid_r;
  logic                s1_valid_nxt;
  bgi_item_t           s1_item_r;
  logic [ADC_BITS-1:0] s1_level_r;
  logic                s1_adv;

  bgi_state_t          st_r;
  bgi_state_t          st_nxt;
  bgi_blink_t          blink;

  logic                out_valid_r;
  logic                out_valid_nxt;
  bgi_state_t          out_st_r;
  bgi_blink_t          out_blink_r;

  // Threshold registers, always writable
  assign cfg_ch.ready = 1'b1;

  bgi_cfg_regs #(
    .ADC_BITS (ADC_BITS)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .thr      (thr)
  );

  // Advance the held event whenever the result register is free or draining
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.kind                    <= in_ch.kind;
      s1_item_r.mode_value              <= in_ch.mode_value;
      s1_item_r.set_target              <= in_ch.set_target;
      s1_item_r.set_value               <= in_ch.set_value;
      s1_item_r.charge_phase            <= in_ch.charge_phase;
      s1_item_r.setting_exit_event      <= in_ch.setting_exit_event;
      s1_item_r.indicator_exit_event    <= in_ch.indicator_exit_event;
      s1_item_r.lamp_on                 <= in_ch.lamp_on;
      s1_item_r.lamp_allowed_in_setting <= in_ch.lamp_allowed_in_setting;
      s1_level_r                        <= in_ch.battery_level;
    end
  end

  // Event logic
  bgi_event_logic #(
    .ADC_BITS (ADC_BITS)
  ) u_event_logic (
    .item   (s1_item_r),
    .level  (s1_level_r),
    .thr    (thr),
    .st     (st_r),
    .st_nxt (st_nxt),
    .blink  (blink)
  );

  // Gauge state, updated once per event in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_st_r    <= st_nxt;
      out_blink_r <= blink;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.led_pattern    = out_st_r.leds;
  assign out_ch.current_mode   = out_st_r.mode;
  assign out_ch.charging_gear  = out_st_r.charge_gear;
  assign out_ch.discharge_rate = out_st_r.rate_setting;
  assign out_ch.initial_gear   = out_st_r.initial_gear;
  assign out_ch.blink_request  = out_blink_r.request;
  assign out_ch.blink_value    = out_blink_r.value;

endmodule

[design/bgi_checker.sv]
// ----------------------------------------------------------------------------
// bgi_checker
// Port-level checks on the gauge result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bgi_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bgi_pkg::LED_W-1:0]    led_pattern,
  input logic [bgi_pkg::MODE_W-1:0]   current_mode,
  input logic [bgi_pkg::GEAR_W-1:0]   charging_gear,
  input logic                         blink_request,
  input logic [bgi_pkg::VALUE_W-1:0]  blink_value
);
  import bgi_pkg::*;

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Off mode never shows a lit LED
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && current_mode == MODE_OFF |-> led_pattern == '0)
    else $error("LEDs lit in off mode");

  // Blink value is zero without a blink request
  a_blink_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !blink_request |-> blink_value == '0)
    else $error("blink value without request");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(led_pattern) &&
      $stable(current_mode) && $stable(charging_gear) && $stable(blink_value))
    else $error("stalled result changed");

endmodule

bind battery_gauge_led_indicator_unit bgi_checker u_bgi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .led_pattern   (out_ch.led_pattern),
  .current_mode  (out_ch.current_mode),
  .charging_gear (out_ch.charging_gear),
  .blink_request (out_ch.blink_request),
  .blink_value   (out_ch.blink_value)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery gauge LED indicator. An initial block
// queues events (a directed opening, then random discharge, charging and
// setting sequences mixed with noise) under several threshold settings. A
// clocked driver presents them with random gaps, a gauge predictor works out
// the result of each accepted event, and a clocked monitor stalls the result
// side at random and compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgi_pkg::*;

  localparam int ADC_W       = ADC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  // Codes outside the named ranges, used to check that they are ignored
  localparam logic [KIND_W-1:0]  KIND_UNUSED  = 3'd7;
  localparam logic [MODE_W-1:0]  MODE_UNUSED  = 3'd7;
  localparam logic [PHASE_W-1:0] PHASE_NORMAL = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_UNUSED = 2'd3;

  typedef struct packed {
    bgi_item_t          ev;
    logic [ADC_W-1:0]   level;
  } gauge_event_t;

  typedef struct packed {
    logic [LED_W-1:0]   leds;
    logic [MODE_W-1:0]  mode;
    logic [GEAR_W-1:0]  charge_gear;
    logic [VALUE_W-1:0] rate;
    logic [VALUE_W-1:0] init_gear;
    bgi_blink_t         blink;
  } gauge_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bgi_in_if  #(.ADC_BITS(ADC_W)) in_ch ();
  bgi_out_if                     out_ch ();
  bgi_cfg_if #(.ADC_BITS(ADC_W)) cfg_ch ();

  battery_gauge_led_indicator_unit #(.ADC_BITS(ADC_W)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted gauge state and thresholds
  bgi_state_t       gauge;
  logic [ADC_W-1:0] level_thr [4];

  gauge_event_t  event_q [$];
  gauge_result_t gauge_result_q [$];
  gauge_event_t  cur_event;
  logic          in_flight;
  int            sender_idle_pct;
  int            receiver_stall_pct;
  int            mismatch_count;
  int            cycle_count;

  always #10 clk = ~clk;

  // Apply one accepted event to the predicted state and queue its result
  function automatic void predict_event(gauge_event_t e);
    gauge_result_t r;
    logic [GEAR_W-1:0] g;
    bgi_blink_t blink;
    blink = '0;
    if (e.level > level_thr[REG_LEVEL_4])      g = GEAR_TOP;
    else if (e.level > level_thr[REG_LEVEL_3]) g = 3'd4;
    else if (e.level > level_thr[REG_LEVEL_2]) g = 3'd3;
    else if (e.level > level_thr[REG_LEVEL_1]) g = 3'd2;
    else                                       g = 3'd1;

    case (e.ev.kind)
      KIND_EVALUATE: begin
        if (gauge.mode == MODE_OFF) begin
          gauge.leds = '0;
        end else begin
          case (gauge.mode)
            MODE_BATTERY: begin
              // discharge: shown gear may only fall
              if (gauge.last_gear != GEAR_NONE && g > gauge.last_gear) g = gauge.last_gear;
              gauge.last_gear = g;
              gauge.leds = 5'b00001;
              if (g >= 3'd2) gauge.leds[1] = 1'b1;
              if (g >= 3'd3) gauge.leds[2] = 1'b1;
              if (g >= 3'd4) gauge.leds[3] = 1'b1;
              if (g >= GEAR_TOP) gauge.leds[4] = 1'b1;
            end
            MODE_RATE_SET, MODE_RATE_SHOW: begin
              if (gauge.rate_setting == RATE_ONE)        gauge.leds[0] = 1'b1;
              else if (gauge.rate_setting == RATE_TWO)   gauge.leds[1] = 1'b1;
              else if (gauge.rate_setting == RATE_THREE) gauge.leds[2] = 1'b1;
            end
            MODE_CHARGING: begin
              // charging: shown gear may only rise, near full forces the top
              if (e.ev.charge_phase == PHASE_TRICKLE || e.ev.charge_phase == PHASE_FULL)
                g = GEAR_FULL;
              if (gauge.last_gear != GEAR_NONE && g < gauge.last_gear) g = gauge.last_gear;
              gauge.last_gear   = g;
              gauge.charge_gear = g;
              gauge.leds[0] = 1'b1;
              if (g >= 3'd3) gauge.leds[1] = 1'b1;
              if (g >= 3'd4) gauge.leds[2] = 1'b1;
              if (g >= GEAR_TOP) gauge.leds[3] = 1'b1;
              if (g >= GEAR_FULL) gauge.leds[4] = 1'b1;
            end
            default: ;
          endcase
          // exit events: setting exit first, indicator exit wins
          if (e.ev.setting_exit_event) begin
            gauge.mode = (e.ev.lamp_on && !e.ev.lamp_allowed_in_setting) ?
                         MODE_BATTERY : MODE_OFF;
            gauge.in_setting = 1'b0;
          end
          if (e.ev.indicator_exit_event) gauge.mode = MODE_OFF;
          if (gauge.mode == MODE_OFF) gauge.leds = '0;
        end
      end
      KIND_MODE: begin
        if (e.ev.mode_value <= MODE_CHARGING) begin
          gauge.leds = '0;
          gauge.mode = e.ev.mode_value;
        end
      end
      KIND_SET_WRITE: begin
        if (gauge.in_setting) begin
          if (e.ev.set_target) begin
            gauge.rate_setting = e.ev.set_value;
            gauge.mode = MODE_RATE_SET;
          end else begin
            gauge.initial_gear = e.ev.set_value;
            gauge.mode = MODE_GEAR_SET;
          end
          gauge.leds = '0;
          blink.request = 1'b1;
          blink.value   = e.ev.set_value;
        end
      end
      KIND_REFRESH: begin
        gauge.leds = '0;
        gauge.last_gear = GEAR_NONE;
        gauge.charge_gear = GEAR_NONE;
      end
      KIND_ENTER_SET: gauge.in_setting = 1'b1;
      default: ;
    endcase

    r.leds        = gauge.leds;
    r.mode        = gauge.mode;
    r.charge_gear = gauge.charge_gear;
    r.rate        = gauge.rate_setting;
    r.init_gear   = gauge.initial_gear;
    r.blink       = blink;
    gauge_result_q.push_back(r);
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic gauge_event_t make_event(logic [KIND_W-1:0] k,
                                              logic [ADC_W-1:0] lvl = '0,
                                              logic [PHASE_W-1:0] ph = PHASE_NORMAL,
                                              logic [MODE_W-1:0] mv = MODE_OFF,
                                              logic tgt = 1'b0,
                                              logic [VALUE_W-1:0] val = '0,
                                              logic sx = 1'b0,
                                              logic ix = 1'b0,
                                              logic lamp = 1'b0,
                                              logic allow = 1'b0);
    gauge_event_t e;
    e.ev.kind = k;
    e.ev.mode_value = mv;
    e.ev.set_target = tgt;
    e.ev.set_value = val;
    e.ev.charge_phase = ph;
    e.ev.setting_exit_event = sx;
    e.ev.indicator_exit_event = ix;
    e.ev.lamp_on = lamp;
    e.ev.lamp_allowed_in_setting = allow;
    e.level = lvl;
    return e;
  endfunction

  function automatic gauge_event_t random_event();
    gauge_event_t e;
    logic [31:0] bits;
    bits = $urandom;
    e.ev = bits[$bits(bgi_item_t)-1:0];
    e.level = $urandom_range((1 << ADC_W) - 1);
    return e;
  endfunction

  // Random filler with exit events kept rare, so that a mode persists
  function automatic gauge_event_t calm_event(logic [KIND_W-1:0] k);
    gauge_event_t e;
    e = random_event();
    e.ev.kind = k;
    e.ev.setting_exit_event = ($urandom_range(11) == 0);
    e.ev.indicator_exit_event = ($urandom_range(15) == 0);
    return e;
  endfunction

  // Level at an extreme, next to a threshold, or anywhere
  function automatic logic [ADC_W-1:0] pick_level();
    int v;
    case ($urandom_range(3))
      0: v = 0;
      1: v = (1 << ADC_W) - 1;
      2: begin
        v = int'(level_thr[$urandom_range(3)]) + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > (1 << ADC_W) - 1) v = (1 << ADC_W) - 1;
      end
      default: v = $urandom_range((1 << ADC_W) - 1);
    endcase
    return v[ADC_W-1:0];
  endfunction

  function automatic logic [PHASE_W-1:0] pick_phase();
    case ($urandom_range(9))
      7: return PHASE_TRICKLE;
      8: return PHASE_FULL;
      9: return PHASE_UNUSED;
      default: return PHASE_NORMAL;
    endcase
  endfunction

  // Queue one short sequence; return how many events it holds that act
  function automatic int queue_scenario();
    gauge_event_t e;
    int n;
    int pick;
    int lvl;
    n = 0;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // noise over every field
      repeat ($urandom_range(1, 3)) begin
        e = random_event();
        event_q.push_back(e);
        if (e.ev.kind <= KIND_ENTER_SET) n++;
      end
    end else if (pick < 60) begin
      // discharge or charging run with a moving level
      if ($urandom_range(2) == 0) begin
        event_q.push_back(calm_event(KIND_REFRESH));
        n++;
      end
      e = calm_event(KIND_MODE);
      e.ev.mode_value = (pick < 35) ? MODE_BATTERY : MODE_CHARGING;
      e.ev.setting_exit_event = 1'b0;
      event_q.push_back(e);
      n++;
      lvl = pick_level();
      repeat ($urandom_range(2, 8)) begin
        e = calm_event(KIND_EVALUATE);
        if ($urandom_range(2) == 0) begin
          lvl = pick_level();
        end else if (pick < 35) begin
          lvl = lvl - int'($urandom_range(400));
          if (lvl < 0) lvl = 0;
        end else begin
          lvl = lvl + int'($urandom_range(400));
          if (lvl > (1 << ADC_W) - 1) lvl = (1 << ADC_W) - 1;
        end
        e.level = lvl[ADC_W-1:0];
        e.ev.charge_phase = pick_phase();
        event_q.push_back(e);
        n++;
      end
    end else if (pick < 85) begin
      // setting session: enter, writes and evaluates, an exit half the time
      event_q.push_back(calm_event(KIND_ENTER_SET));
      n++;
      repeat ($urandom_range(1, 3)) begin
        e = calm_event(KIND_SET_WRITE);
        e.ev.set_value = ($urandom_range(3) != 0) ? $urandom_range(4) : $urandom_range(255);
        event_q.push_back(e);
        n++;
        repeat ($urandom_range(0, 2)) begin
          e = calm_event(KIND_EVALUATE);
          e.ev.setting_exit_event = 1'b0;
          e.ev.indicator_exit_event = 1'b0;
          event_q.push_back(e);
          n++;
        end
      end
      e = calm_event(KIND_EVALUATE);
      e.ev.setting_exit_event = ($urandom_range(1) == 1);
      event_q.push_back(e);
      n++;
    end else begin
      // rate show, gear set or off with a few evaluates
      e = calm_event(KIND_MODE);
      case ($urandom_range(2))
        0: e.ev.mode_value = MODE_RATE_SHOW;
        1: e.ev.mode_value = MODE_GEAR_SET;
        default: e.ev.mode_value = MODE_OFF;
      endcase
      event_q.push_back(e);
      n++;
      repeat ($urandom_range(1, 4)) begin
        event_q.push_back(calm_event(KIND_EVALUATE));
        n++;
      end
    end
    return n;
  endfunction

  task automatic queue_random(int target);
    int queued;
    queued = 0;
    while (queued < target) queued += queue_scenario();
  endtask

  // Hold until every event is taken and every result has come
  task automatic wait_drained();
    do @(posedge clk);
    while (event_q.size() != 0 || in_flight || gauge_result_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [ADC_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    level_thr[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_thresholds(logic [ADC_W-1:0] t1, logic [ADC_W-1:0] t2,
                                 logic [ADC_W-1:0] t3, logic [ADC_W-1:0] t4);
    write_threshold(REG_LEVEL_1, t1);
    write_threshold(REG_LEVEL_2, t2);
    write_threshold(REG_LEVEL_3, t3);
    write_threshold(REG_LEVEL_4, t4);
  endtask

  // Driver: hold the event until taken, then predict it and maybe send the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_event(cur_event);
        in_flight = 1'b0;
      end
      if (!in_flight && event_q.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        cur_event = event_q.pop_front();
        in_flight = 1'b1;
        in_ch.kind                    <= cur_event.ev.kind;
        in_ch.mode_value              <= cur_event.ev.mode_value;
        in_ch.set_target              <= cur_event.ev.set_target;
        in_ch.set_value               <= cur_event.ev.set_value;
        in_ch.battery_level           <= cur_event.level;
        in_ch.charge_phase            <= cur_event.ev.charge_phase;
        in_ch.setting_exit_event      <= cur_event.ev.setting_exit_event;
        in_ch.indicator_exit_event    <= cur_event.ev.indicator_exit_event;
        in_ch.lamp_on                 <= cur_event.ev.lamp_on;
        in_ch.lamp_allowed_in_setting <= cur_event.ev.lamp_allowed_in_setting;
      end
      in_ch.valid <= in_flight;
    end
  end

  // Monitor: check each result transaction, stall at random
  always @(posedge clk) begin
    gauge_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (gauge_result_q.size() == 0) begin
          $display("%0t: result expected none, actual leds %b mode %0d",
                   $time, out_ch.led_pattern, out_ch.current_mode);
          mismatch_count++;
        end else begin
          want = gauge_result_q.pop_front();
          compare_field("led_pattern", want.leds, out_ch.led_pattern);
          compare_field("current_mode", want.mode, out_ch.current_mode);
          compare_field("charging_gear", want.charge_gear, out_ch.charging_gear);
          compare_field("discharge_rate", want.rate, out_ch.discharge_rate);
          compare_field("initial_gear", want.init_gear, out_ch.initial_gear);
          compare_field("blink_request", want.blink.request, out_ch.blink_request);
          compare_field("blink_value", want.blink.value, out_ch.blink_value);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb failed");
    $finish;
  end

  // Stimulus sequence
  initial begin
    logic [ADC_W-1:0] tq [$];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_EVALUATE;
    in_ch.mode_value = MODE_OFF;
    in_ch.set_target = 1'b0;
    in_ch.set_value = '0;
    in_ch.battery_level = '0;
    in_ch.charge_phase = PHASE_NORMAL;
    in_ch.setting_exit_event = 1'b0;
    in_ch.indicator_exit_event = 1'b0;
    in_ch.lamp_on = 1'b0;
    in_ch.lamp_allowed_in_setting = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LEVEL_1;
    cfg_ch.data = '0;
    in_flight = 1'b0;
    mismatch_count = 0;
    sender_idle_pct = 30;
    receiver_stall_pct = 83;
    // state and thresholds as they come out of reset
    gauge = '0;
    level_thr[REG_LEVEL_1] = 12'd1024;
    level_thr[REG_LEVEL_2] = 12'd2048;
    level_thr[REG_LEVEL_3] = 12'd3072;
    level_thr[REG_LEVEL_4] = 12'd3584;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with the default thresholds
    // off: evaluate clears LEDs and ignores both exits
    event_q.push_back(make_event(KIND_EVALUATE, '1, PHASE_NORMAL, MODE_OFF, 1'b0, '0,
                                 1'b1, 1'b1, 1'b1));
    event_q.push_back(make_event(KIND_REFRESH));
    event_q.push_back(make_event(KIND_MODE, '0, PHASE_NORMAL, MODE_UNUSED));
    event_q.push_back(make_event(KIND_UNUSED, '1, PHASE_UNUSED, MODE_CHARGING, 1'b1, '1));
    // setting write outside setting mode is dropped
    event_q.push_back(make_event(KIND_SET_WRITE, '0, PHASE_NORMAL, MODE_OFF, 1'b1, RATE_THREE));
    // discharge: top, bottom, no rise, refresh, threshold edges
    event_q.push_back(make_event(KIND_MODE, '0, PHASE_NORMAL, MODE_BATTERY));
    event_q.push_back(make_event(KIND_EVALUATE, '1));
    event_q.push_back(make_event(KIND_EVALUATE, '0));
    event_q.push_back(make_event(KIND_EVALUATE, '1));
    event_q.push_back(make_event(KIND_REFRESH));
    event_q.push_back(make_event(KIND_EVALUATE, 12'd2048));
    event_q.push_back(make_event(KIND_EVALUATE, 12'd2049));
    // charging: no fall, phase three as normal, trickle and full force the top
    event_q.push_back(make_event(KIND_MODE, '0, PHASE_NORMAL, MODE_CHARGING));
    event_q.push_back(make_event(KIND_EVALUATE, '0, PHASE_NORMAL));
    event_q.push_back(make_event(KIND_EVALUATE, 12'd3585, PHASE_UNUSED));
    event_q.push_back(make_event(KIND_EVALUATE, '0, PHASE_TRICKLE));
    event_q.push_back(make_event(KIND_EVALUATE, '0, PHASE_FULL));
    // setting: rate two, rate out of range, gear set, exit to battery
    event_q.push_back(make_event(KIND_ENTER_SET));
    event_q.push_back(make_event(KIND_SET_WRITE, '0, PHASE_NORMAL, MODE_OFF, 1'b1, RATE_TWO));
    event_q.push_back(make_event(KIND_EVALUATE));
    event_q.push_back(make_event(KIND_SET_WRITE, '0, PHASE_NORMAL, MODE_OFF, 1'b1, '1));
    event_q.push_back(make_event(KIND_EVALUATE));
    event_q.push_back(make_event(KIND_SET_WRITE, '0, PHASE_NORMAL, MODE_OFF, 1'b0, '1));
    event_q.push_back(make_event(KIND_EVALUATE, '0, PHASE_NORMAL, MODE_OFF, 1'b0, '0,
                                 1'b1, 1'b0, 1'b1, 1'b0));
    // rate show exiting to off, charging dropped by the indicator exit
    event_q.push_back(make_event(KIND_MODE, '0, PHASE_NORMAL, MODE_RATE_SHOW));
    event_q.push_back(make_event(KIND_EVALUATE, '0, PHASE_NORMAL, MODE_OFF, 1'b0, '0,
                                 1'b1, 1'b0, 1'b1, 1'b1));
    event_q.push_back(make_event(KIND_MODE, '0, PHASE_NORMAL, MODE_CHARGING));
    event_q.push_back(make_event(KIND_EVALUATE, 12'd3000, PHASE_NORMAL, MODE_OFF, 1'b0, '0,
                                 1'b0, 1'b1));

    // Random phases, each under its own thresholds; idling pattern changes at phases 2 and 4
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        sender_idle_pct = 83;
        receiver_stall_pct = 30;
      end
      if (ph == 4) begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      wait_drained();
      tq.delete();
      repeat (4) tq.push_back($urandom_range((1 << ADC_W) - 1));
      case (ph)
        1: load_thresholds('0, '0, '0, '0);
        2: load_thresholds('1, '1, '1, '1);
        3: begin
          tq.sort();
          load_thresholds(tq[0], tq[1], tq[2], tq[3]);
        end
        4: load_thresholds(tq[0], tq[1], tq[2], tq[3]);
        5: load_thresholds(12'd2000, 12'd2001, 12'd2002, 12'd2003);
        default: ;
      endcase
      queue_random(125);
      // let every result come back before the rest of the phase
      wait_drained();
      queue_random(125);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
